// ----- src/ssh_pkg.sv -----
// ============================================================================
// ssh_pkg - shared types and constants for the speech segment segmenter
// Widths, hysteresis constants, register indexes and interface structs.
// ============================================================================
package ssh_pkg;

    localparam int FRAME_BITS = 24;
    localparam int PROB_BITS  = 16;
    localparam int CFG_BITS   = 16;
    localparam int SEG_BITS   = 24;
    localparam int CMP_BITS   = (FRAME_BITS > CFG_BITS) ? FRAME_BITS : CFG_BITS;

    // 0.15 and 0.01 in Q0.PROB_BITS, rounded to nearest
    localparam longint OFF_DELTA_L = ((longint'(15) << PROB_BITS) + 50) / 100;
    localparam longint OFF_FLOOR_L = ((longint'(1) << PROB_BITS) + 50) / 100;

    localparam logic [PROB_BITS-1:0] OFF_DELTA = PROB_BITS'(OFF_DELTA_L);
    localparam logic [PROB_BITS-1:0] OFF_FLOOR = PROB_BITS'(OFF_FLOOR_L);
    localparam logic [PROB_BITS:0]   OFF_KNEE  = (PROB_BITS+1)'(OFF_DELTA_L + OFF_FLOOR_L);

    localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

    // register indexes
    localparam logic [1:0] REG_ON_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_MIN_SPEECH    = 2'd1;
    localparam logic [1:0] REG_MIN_SILENCE   = 2'd2;

    localparam logic [CFG_BITS-1:0] ON_RESET      = 16'd32768;
    localparam logic [CFG_BITS-1:0] MIN_SP_RESET  = 16'd12;
    localparam logic [CFG_BITS-1:0] MIN_SIL_RESET = 16'd5;

    typedef struct packed {
        logic [PROB_BITS-1:0] on_thr;
        logic [PROB_BITS-1:0] off_thr;
        logic [CFG_BITS-1:0]  min_speech;
        logic [CFG_BITS-1:0]  min_silence;
    } cfg_t;

    typedef struct packed {
        logic [PROB_BITS-1:0] prob;
        logic                 last;
    } frame_t;

    typedef struct packed {
        logic                emit;
        logic [SEG_BITS-1:0] start;
        logic [SEG_BITS-1:0] stop;
    } seg_t;

    // off = max(on - 0.15, 0.01)
    function automatic logic [PROB_BITS-1:0] off_of(input logic [PROB_BITS-1:0] on);
        logic [PROB_BITS-1:0] res;
        if ({1'b0, on} >= OFF_KNEE)
            res = on - OFF_DELTA;
        else
            res = OFF_FLOOR;
        return res;
    endfunction

endpackage

// ----- src/speech_segment_hysteresis.sv -----
// ============================================================================
// speech_segment_hysteresis - speech segment detector with hysteresis
// Turns per-frame speech probabilities into [start, end) frame segments.
// ============================================================================
//
//  channel   | direction | payload
//  ----------+-----------+-----------------------------------------------
//  s_axis    | in        | tdata[15:0] prob_value, tlast last_frame
//  m_axis    | out       | tdata[23:0] seg_start, tdata[47:24] seg_end
//  cfg       | in        | cfg_index 0 on, 1 min speech, 2 min silence
//
//  One frame per cycle sustained while the result slot is free. A frame is
//  held in the input register and its segment, if any, is written to the
//  result register when the frame advances through the decision.
//  Reset clears the segment state, frame counter and both valid flags and
//  loads the default settings. A held result stalls the input only once the
//  input register is also full.
//
module speech_segment_hysteresis (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] prob_value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,    // [23:0] seg_start, [47:24] seg_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ssh_pkg::*;

    cfg_t   cfg;
    frame_t in_frame;
    frame_t frame;
    seg_t   seg;
    logic   frame_valid;
    logic   advance;

    assign in_frame.prob = PROB_BITS'(s_axis_tdata);
    assign in_frame.last = s_axis_tlast;

    // move the held frame through the decision when the result slot is free
    assign advance = frame_valid && (!m_axis_tvalid || m_axis_tready);

    ssh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssh_in_reg u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_frame    (in_frame),
        .advance     (advance),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    ssh_tracker u_trk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .frame   (frame),
        .advance (advance),
        .seg     (seg)
    );

    ssh_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .seg       (seg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // input stalls only behind a result that is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // a segment never ends before it starts
    a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[47:24] >= m_axis_tdata[23:0]))
        else $error("segment end precedes start");

    // a frame that advances leaves the input register free or refilled
    a_adv_free: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> s_axis_tready)
        else $error("input not ready while frame advances");

endmodule

// ----- src/ssh_cfg_regs.sv -----
// ============================================================================
// ssh_cfg_regs - configuration registers
// Holds the three settings and keeps the derived off threshold registered.
// ============================================================================
module ssh_cfg_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    output ssh_pkg::cfg_t           cfg
);
    import ssh_pkg::*;

    logic [PROB_BITS-1:0] on_reg;
    logic [PROB_BITS-1:0] off_reg;
    logic [CFG_BITS-1:0]  min_sp_reg;
    logic [CFG_BITS-1:0]  min_sil_reg;
    logic [PROB_BITS-1:0] on_next;

    assign on_next = PROB_BITS'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg      <= PROB_BITS'(ON_RESET);
            off_reg     <= off_of(PROB_BITS'(ON_RESET));
            min_sp_reg  <= MIN_SP_RESET;
            min_sil_reg <= MIN_SIL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ON_THRESHOLD:
                begin
                    on_reg  <= on_next;
                    off_reg <= off_of(on_next);
                end
                REG_MIN_SPEECH:  min_sp_reg  <= cfg_data;
                REG_MIN_SILENCE: min_sil_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.on_thr      = on_reg;
    assign cfg.off_thr     = off_reg;
    assign cfg.min_speech  = min_sp_reg;
    assign cfg.min_silence = min_sil_reg;

endmodule

// ----- src/ssh_in_reg.sv -----
// ============================================================================
// ssh_in_reg - input register
// Captures one frame; frees itself when the decision stage advances.
// ============================================================================
module ssh_in_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ssh_pkg::frame_t         in_frame,
    input  logic                    advance,
    output logic                    frame_valid,
    output ssh_pkg::frame_t         frame
);
    import ssh_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            frame_reg <= in_frame;
    end

    assign frame_valid = valid_reg;
    assign frame       = frame_reg;

endmodule

// ----- src/ssh_tracker.sv -----
// ============================================================================
// ssh_tracker - segment state and hysteresis decision
// Updates speaking, onset, pending end and frame counter for one frame.
// ============================================================================
module ssh_tracker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ssh_pkg::cfg_t           cfg,
    input  ssh_pkg::frame_t         frame,
    input  logic                    advance,
    output ssh_pkg::seg_t           seg
);
    import ssh_pkg::*;

    logic                  speaking_reg, speaking_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [FRAME_BITS-1:0] onset_reg, onset_next;
    logic [FRAME_BITS-1:0] pend_reg, pend_next;
    logic [FRAME_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        logic                  hot;
        logic                  quiet;
        logic                  opened;
        logic [FRAME_BITS-1:0] cnt_inc;
        logic [FRAME_BITS-1:0] idle_len;
        logic [FRAME_BITS-1:0] seg_len;
        logic [FRAME_BITS-1:0] flush_len;

        idle_len  = '0;
        seg_len   = '0;
        flush_len = '0;

        hot    = frame.prob >= cfg.on_thr;
        quiet  = frame.prob < cfg.off_thr;
        opened = hot && !speaking_reg;

        speaking_next   = speaking_reg || opened;
        onset_next      = opened ? count_reg : onset_reg;
        pend_valid_next = pend_valid_reg && !opened;
        pend_next       = opened ? '0 : pend_reg;

        seg.emit  = 1'b0;
        seg.start = SEG_BITS'(onset_next);
        seg.stop  = SEG_BITS'(pend_next);

        if (quiet && speaking_next)
        begin
            if (!pend_valid_next)
                pend_next = count_reg;
            pend_valid_next = 1'b1;
            idle_len = count_reg - pend_next;
            seg_len  = pend_next - onset_next;
            seg.stop = SEG_BITS'(pend_next);
            if (CMP_BITS'(idle_len) >= CMP_BITS'(cfg.min_silence))
            begin
                seg.emit        = CMP_BITS'(seg_len) >= CMP_BITS'(cfg.min_speech);
                speaking_next   = 1'b0;
                pend_valid_next = 1'b0;
                pend_next       = '0;
            end
        end
        else if (hot && pend_valid_next)
        begin
            pend_valid_next = 1'b0;
            pend_next       = '0;
        end

        cnt_inc    = (count_reg == FRAME_MAX) ? FRAME_MAX : count_reg + FRAME_BITS'(1);
        count_next = cnt_inc;

        // end of stream: flush an open segment and restart numbering
        if (frame.last)
        begin
            flush_len = cnt_inc - onset_next;
            if (speaking_next && CMP_BITS'(flush_len) >= CMP_BITS'(cfg.min_speech))
            begin
                seg.emit = 1'b1;
                seg.stop = SEG_BITS'(cnt_inc);
            end
            speaking_next   = 1'b0;
            onset_next      = '0;
            pend_valid_next = 1'b0;
            pend_next       = '0;
            count_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speaking_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            onset_reg      <= '0;
            pend_reg       <= '0;
            count_reg      <= '0;
        end
        else if (advance)
        begin
            speaking_reg   <= speaking_next;
            pend_valid_reg <= pend_valid_next;
            onset_reg      <= onset_next;
            pend_reg       <= pend_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ----- src/ssh_out_reg.sv -----
// ============================================================================
// ssh_out_reg - result register
// Holds one finished segment until the downstream side takes it.
// ============================================================================
module ssh_out_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  ssh_pkg::seg_t           seg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [47:0]             out_data
);
    import ssh_pkg::*;

    logic                valid_reg, valid_next;
    logic [SEG_BITS-1:0] start_reg;
    logic [SEG_BITS-1:0] stop_reg;

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        if (advance)
            valid_next = seg.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && seg.emit)
        begin
            start_reg <= seg.start;
            stop_reg  <= seg.stop;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {stop_reg, start_reg};

endmodule
